[sv/xce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XML character escape package
// Shared types, constants and byte generation for the escape datapath.
// ----------------------------------------------------------------------------
package xce_pkg;

	localparam int unsigned CP_W       = 21;
	localparam int unsigned BMP_W      = 16;
	localparam int unsigned IDX_W      = 3;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [BMP_W-1:0] CP_TAB      = 16'h0009;
	localparam logic [BMP_W-1:0] CP_LF       = 16'h000A;
	localparam logic [BMP_W-1:0] CP_CR       = 16'h000D;
	localparam logic [BMP_W-1:0] CP_SPACE    = 16'h0020;
	localparam logic [BMP_W-1:0] CP_QUOT     = 16'h0022;
	localparam logic [BMP_W-1:0] CP_AMP      = 16'h0026;
	localparam logic [BMP_W-1:0] CP_APOS     = 16'h0027;
	localparam logic [BMP_W-1:0] CP_LT       = 16'h003C;
	localparam logic [BMP_W-1:0] CP_GT       = 16'h003E;
	localparam logic [BMP_W-1:0] CP_BSLASH   = 16'h005C;
	localparam logic [BMP_W-1:0] CP_PRINT_LO = 16'h0021;
	localparam logic [BMP_W-1:0] CP_SURR_LO  = 16'hD7FF;
	localparam logic [BMP_W-1:0] CP_PRIV_LO  = 16'hE000;
	localparam logic [BMP_W-1:0] CP_BMP_HI   = 16'hFFFD;
	localparam logic [BMP_W-1:0] CP_ONE_LIM  = 16'h0080;
	localparam logic [BMP_W-1:0] CP_TWO_LIM  = 16'h0800;

	// Escape texts, first byte in the top bits
	localparam logic [63:0] TXT_AMP  = {"&amp;", 24'h0};
	localparam logic [63:0] TXT_LT   = {"&lt;", 32'h0};
	localparam logic [63:0] TXT_GT   = {"&gt;", 32'h0};
	localparam logic [63:0] TXT_APOS = {"&apos;", 16'h0};
	localparam logic [63:0] TXT_QUOT = {"&quot;", 16'h0};
	localparam logic [63:0] TXT_HEX  = "&#x00hh;";

	typedef enum logic [3:0] {
		K_AMP,
		K_LT,
		K_GT,
		K_APOS,
		K_QUOT,
		K_BSL,
		K_HEX,
		K_UTF1,
		K_UTF2,
		K_UTF3
	} xce_kind_t;

	typedef struct packed {
		xce_kind_t        kind;
		logic [BMP_W-1:0] cp;
	} xce_desc_t;

	typedef struct packed {
		logic valid;
		logic full;
	} xce_q_stat_t;

	function automatic logic [IDX_W-1:0] last_idx(input xce_kind_t kind);
		logic [IDX_W-1:0] r;
		case (kind)
			K_AMP:   r = 3'd4;
			K_LT:    r = 3'd3;
			K_GT:    r = 3'd3;
			K_APOS:  r = 3'd5;
			K_QUOT:  r = 3'd5;
			K_BSL:   r = 3'd1;
			K_HEX:   r = 3'd7;
			K_UTF1:  r = 3'd0;
			K_UTF2:  r = 3'd1;
			K_UTF3:  r = 3'd2;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
	endfunction

	function automatic logic [7:0] pick(input logic [63:0] txt, input logic [IDX_W-1:0] idx);
		return txt[{3'd7 - idx, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] byte_at(input xce_desc_t d, input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (d.kind)
			K_AMP, K_LT, K_GT, K_APOS, K_QUOT: begin
				case (d.kind)
					K_AMP:   b = pick(TXT_AMP, idx);
					K_LT:    b = pick(TXT_LT, idx);
					K_GT:    b = pick(TXT_GT, idx);
					K_APOS:  b = pick(TXT_APOS, idx);
					K_QUOT:  b = pick(TXT_QUOT, idx);
					default: b = 8'h00;
				endcase
			end
			K_BSL: b = CP_BSLASH[7:0];
			K_HEX: begin
				case (idx)
					3'd5:    b = hex_digit(d.cp[7:4]);
					3'd6:    b = hex_digit(d.cp[3:0]);
					default: b = pick(TXT_HEX, idx);
				endcase
			end
			K_UTF1: b = d.cp[7:0];
			K_UTF2: b = (idx == 3'd0) ? {3'b110, d.cp[10:6]} : {2'b10, d.cp[5:0]};
			K_UTF3: begin
				case (idx)
					3'd0:    b = {4'hE, d.cp[15:12]};
					3'd1:    b = {2'b10, d.cp[11:6]};
					default: b = {2'b10, d.cp[5:0]};
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

[sv/xce_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XML escape front end
// Accepts code points, classifies them and drops those with no output.
// ----------------------------------------------------------------------------
module xce_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire logic [xce_pkg::CP_W-1:0]     in_cp,
	output      logic                         out_valid,
	output      xce_pkg::xce_desc_t           out_desc,
	input  wire logic                         out_ready
);

	logic                       valid_s1;
	xce_pkg::xce_desc_t         desc_s1;
	logic [xce_pkg::BMP_W-1:0]  cp;
	logic                       keep;
	xce_pkg::xce_kind_t         kind;

	assign cp = in_cp[xce_pkg::BMP_W-1:0];

	always_comb begin
		keep = 1'b1;
		kind = xce_pkg::K_UTF1;
		if (in_cp[xce_pkg::CP_W-1:xce_pkg::BMP_W] != '0) begin
			keep = 1'b0;
		end else if (cp == xce_pkg::CP_AMP) begin
			kind = xce_pkg::K_AMP;
		end else if (cp == xce_pkg::CP_LT) begin
			kind = xce_pkg::K_LT;
		end else if (cp == xce_pkg::CP_GT) begin
			kind = xce_pkg::K_GT;
		end else if (cp == xce_pkg::CP_APOS) begin
			kind = xce_pkg::K_APOS;
		end else if (cp == xce_pkg::CP_QUOT) begin
			kind = xce_pkg::K_QUOT;
		end else if (cp == xce_pkg::CP_BSLASH) begin
			kind = xce_pkg::K_BSL;
		end else if (cp == xce_pkg::CP_TAB || cp == xce_pkg::CP_LF ||
		             cp == xce_pkg::CP_CR || cp == xce_pkg::CP_SPACE) begin
			kind = xce_pkg::K_HEX;
		end else if (!((cp >= xce_pkg::CP_PRINT_LO && cp <= xce_pkg::CP_SURR_LO) ||
		               (cp >= xce_pkg::CP_PRIV_LO && cp <= xce_pkg::CP_BMP_HI))) begin
			keep = 1'b0;
		end else if (cp < xce_pkg::CP_ONE_LIM) begin
			kind = xce_pkg::K_UTF1;
		end else if (cp < xce_pkg::CP_TWO_LIM) begin
			kind = xce_pkg::K_UTF2;
		end else begin
			kind = xce_pkg::K_UTF3;
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_desc  = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			desc_s1.kind <= kind;
			desc_s1.cp   <= cp;
		end
	end

endmodule
`default_nettype wire

[sv/xce_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XML escape descriptor queue
// Short first-in first-out buffer between front end and serialiser.
// ----------------------------------------------------------------------------
module xce_queue #(
	parameter int unsigned DEPTH = xce_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire xce_pkg::xce_desc_t push_desc,
	input  wire logic               pop,
	output      xce_pkg::xce_desc_t head_desc,
	output      xce_pkg::xce_q_stat_t stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	xce_pkg::xce_desc_t mem_q [DEPTH];
	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               do_push;
	logic               do_pop;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == CW'(DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;
	assign head_desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule
`default_nettype wire

[sv/xce_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XML escape serialiser
// Expands one descriptor into its output bytes, one byte per transaction.
// ----------------------------------------------------------------------------
module xce_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire xce_pkg::xce_desc_t  head_desc,
	output      logic                pop,
	output      logic                out_valid,
	output      logic [7:0]          out_byte,
	output      logic                out_last,
	input  wire logic                out_ready
);

	logic [xce_pkg::IDX_W-1:0] idx_q;
	logic                      valid_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      load;
	logic                      at_last;

	assign load      = head_valid && (!valid_q || out_ready);
	assign at_last   = (idx_q == xce_pkg::last_idx(head_desc.kind));
	assign pop       = load && at_last;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? '0 : idx_q + xce_pkg::IDX_W'(1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= xce_pkg::byte_at(head_desc, idx_q);
			last_q <= at_last;
		end
	end

endmodule
`default_nettype wire

[sv/xml_char_escape_utf8.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XML character escape to UTF-8
// Escapes one code point per transaction into XML-safe UTF-8 bytes.
//
// Channel  Dir  Width  Content
// s_*      in   24     tdata[20:0] code_point, upper bits zero
// m_*      out  8      tdata[7:0] out_byte, tlast last_byte
//
// One code point per cycle while each gives one byte and m_tready stays high; an
// escape of n bytes leaves through the single-byte output register one byte at a time.
// The path from input to first byte is registered in classify, queue and output.
// Rejected code points are dropped in the front end and give no transaction.
// Reset clears the valid flags and queue pointers; data registers are not reset.
// The queue lets the input keep flowing while long escapes drain.
// ----------------------------------------------------------------------------
module xml_char_escape_utf8 #(
	parameter int unsigned QUEUE_DEPTH = xce_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,   // [7:0] out_byte
	output      logic        m_tlast
);

	logic                 f_valid;
	xce_pkg::xce_desc_t   f_desc;
	xce_pkg::xce_desc_t   q_head;
	xce_pkg::xce_q_stat_t q_stat;
	logic                 q_pop;

	xce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cp     (s_tdata[xce_pkg::CP_W-1:0]),
		.out_valid (f_valid),
		.out_desc  (f_desc),
		.out_ready (!q_stat.full)
	);

	xce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_desc (f_desc),
		.pop       (q_pop),
		.head_desc (q_head),
		.stat      (q_stat)
	);

	xce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_stat.valid),
		.head_desc  (q_head),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_byte   (m_tdata),
		.out_last   (m_tlast),
		.out_ready  (m_tready)
	);

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (m_tvalid && m_tlast))
		else $error("queue popped without a last byte loaded");

	a_drop_supplementary: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[20:16] != 5'd0) |=> !f_valid)
		else $error("code point above the basic plane was not dropped");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && !q_stat.full) |=> q_stat.valid)
		else $error("pushed descriptor missing from queue");

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML character escape to UTF-8 testbench
// Streams code points into the escaper and predicts the bytes of each escape
// (named entities, doubled backslash, hex references, UTF-8 of one to three
// bytes, silent rejection). Every output transaction is checked in order.
// Both sides idle at random; the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LATENCY_CYCLES = 16;
	localparam int LONG_HOLD      = 300;

	typedef logic [xce_pkg::CP_W-1:0] cp_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} escaped_byte_t;

	class escape_scoreboard;
		escaped_byte_t pending_bytes[$];
		int errors;
		int accepted;
		int rejected;
		int bytes_checked;
		int kind_hits[10];

		function logic [7:0] ascii_hex(logic [3:0] nib);
			if (nib > 4'd9)
				return 8'h61 + 8'(nib - 4'd10);
			return 8'h30 + 8'(nib);
		endfunction

		function void note_code_point(cp_t cp);
			logic [7:0] seq[$];
			logic [7:0] tail[$];
			string text;
			xce_pkg::xce_kind_t kind;
			escaped_byte_t item;
			bit emits;
			emits = 1'b1;
			text = "";
			kind = xce_pkg::K_UTF1;
			accepted++;
			if (cp == {5'd0, xce_pkg::CP_AMP}) begin
				kind = xce_pkg::K_AMP;
				text = "&amp;";
			end else if (cp == {5'd0, xce_pkg::CP_LT}) begin
				kind = xce_pkg::K_LT;
				text = "&lt;";
			end else if (cp == {5'd0, xce_pkg::CP_GT}) begin
				kind = xce_pkg::K_GT;
				text = "&gt;";
			end else if (cp == {5'd0, xce_pkg::CP_APOS}) begin
				kind = xce_pkg::K_APOS;
				text = "&apos;";
			end else if (cp == {5'd0, xce_pkg::CP_QUOT}) begin
				kind = xce_pkg::K_QUOT;
				text = "&quot;";
			end else if (cp == {5'd0, xce_pkg::CP_BSLASH}) begin
				kind = xce_pkg::K_BSL;
				text = "\\\\";
			end else if (cp == {5'd0, xce_pkg::CP_TAB} || cp == {5'd0, xce_pkg::CP_LF} ||
					cp == {5'd0, xce_pkg::CP_CR} || cp == {5'd0, xce_pkg::CP_SPACE}) begin
				kind = xce_pkg::K_HEX;
				text = "&#x00";
				tail = '{ascii_hex(cp[7:4]), ascii_hex(cp[3:0]), 8'h3B};
			end else if (!((cp >= {5'd0, xce_pkg::CP_PRINT_LO} &&
					cp <= {5'd0, xce_pkg::CP_SURR_LO}) ||
					(cp >= {5'd0, xce_pkg::CP_PRIV_LO} &&
					cp <= {5'd0, xce_pkg::CP_BMP_HI}))) begin
				emits = 1'b0;
			end else if (cp < {5'd0, xce_pkg::CP_ONE_LIM}) begin
				kind = xce_pkg::K_UTF1;
				tail = '{cp[7:0]};
			end else if (cp < {5'd0, xce_pkg::CP_TWO_LIM}) begin
				kind = xce_pkg::K_UTF2;
				tail = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
			end else begin
				kind = xce_pkg::K_UTF3;
				tail = '{{4'hE, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
			end
			if (!emits) begin
				rejected++;
				return;
			end
			for (int i = 0; i < text.len(); i++)
				seq = {seq, text.getc(i)};
			seq = {seq, tail};
			kind_hits[kind]++;
			foreach (seq[i]) begin
				item.out_byte  = seq[i];
				item.last_byte = (i == seq.size() - 1);
				pending_bytes = {pending_bytes, item};
			end
		endfunction

		function void check_byte(logic [7:0] out_byte, logic last_byte);
			escaped_byte_t want;
			if (pending_bytes.size() == 0) begin
				$error("unexpected output transaction: out_byte %h last_byte %b",
					out_byte, last_byte);
				errors++;
				return;
			end
			want = pending_bytes.pop_front();
			bytes_checked++;
			if (out_byte !== want.out_byte) begin
				$error("out_byte mismatch: expected %h, actual %h", want.out_byte, out_byte);
				errors++;
			end
			if (last_byte !== want.last_byte) begin
				$error("last_byte mismatch: expected %b, actual %b", want.last_byte, last_byte);
				errors++;
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [23:0] s_tdata  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	bit idling_on = 1'b1;
	int hold_left = 0;
	escape_scoreboard sb = new;

	xml_char_escape_utf8 u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("xml_char_escape_utf8 test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_byte(m_tdata, m_tlast);
	end

	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (idling_on && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 10);
			end
		end
	end

	task automatic send_code_point(input cp_t cp);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 10)) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, cp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_code_point(cp);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_bytes.size() != 0)
			@(posedge clk);
		repeat (LATENCY_CYCLES)
			@(posedge clk);
	endtask

	function automatic cp_t random_code_point();
		int pick;
		cp_t cp;
		logic [xce_pkg::BMP_W-1:0] specials[10];
		specials = '{xce_pkg::CP_AMP, xce_pkg::CP_LT, xce_pkg::CP_GT, xce_pkg::CP_APOS,
			xce_pkg::CP_QUOT, xce_pkg::CP_BSLASH, xce_pkg::CP_TAB, xce_pkg::CP_LF,
			xce_pkg::CP_CR, xce_pkg::CP_SPACE};
		pick = $urandom_range(0, 99);
		if (pick < 35)
			cp = cp_t'($urandom_range(21'h21, 21'h7E));
		else if (pick < 45)
			cp = {5'd0, specials[$urandom_range(0, 9)]};
		else if (pick < 50)
			cp = cp_t'($urandom_range(0, 21'h20));
		else if (pick < 64)
			cp = cp_t'($urandom_range(21'h80, 21'h7FF));
		else if (pick < 79)
			cp = cp_t'($urandom_range(21'h800, 21'hFFFF));
		else if (pick < 83)
			cp = cp_t'($urandom_range(21'hD800, 21'hDFFF));
		else if (pick < 87)
			cp = 21'hFFFC + cp_t'($urandom_range(0, 3));
		else if (pick < 93)
			cp = cp_t'($urandom_range(21'h10000, 21'h10FFFF));
		else
			cp = cp_t'($urandom_range(0, 21'h1FFFFF));
		return cp;
	endfunction

	initial begin
		cp_t corner_points[25];
		corner_points = '{21'h26, 21'h3C, 21'h3E, 21'h27, 21'h22, 21'h5C,
			21'h09, 21'h0A, 21'h0D, 21'h20, 21'h00, 21'h21, 21'h7F, 21'h80,
			21'h7FF, 21'h800, 21'hD7FF, 21'hD800, 21'hE000, 21'hFFFD,
			21'hFFFE, 21'hFFFF, 21'h10000, 21'h10FFFF, 21'h1FFFFF};

		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		foreach (corner_points[k])
			send_code_point(corner_points[k]);
		drain_results();

		while (sb.accepted < 170)
			send_code_point(random_code_point());

		idling_on = 1'b0;
		hold_left = LONG_HOLD;
		repeat (40)
			send_code_point(random_code_point());
		drain_results();

		idling_on = 1'b1;
		while (sb.accepted < 300)
			send_code_point(random_code_point());
		idling_on = 1'b0;
		while (sb.accepted < 360)
			send_code_point(random_code_point());
		idling_on = 1'b1;
		while (sb.accepted < 410)
			send_code_point(random_code_point());
		idling_on = 1'b0;
		while (sb.accepted < 470)
			send_code_point(random_code_point());
		drain_results();

		$display("Covered %0d code points (%0d rejected): %0d named entities,",
			sb.accepted, sb.rejected,
			sb.kind_hits[xce_pkg::K_AMP] + sb.kind_hits[xce_pkg::K_LT] +
			sb.kind_hits[xce_pkg::K_GT] + sb.kind_hits[xce_pkg::K_APOS] +
			sb.kind_hits[xce_pkg::K_QUOT]);
		$display("%0d backslash, %0d hex refs, UTF-8 one/two/three bytes %0d/%0d/%0d,",
			sb.kind_hits[xce_pkg::K_BSL], sb.kind_hits[xce_pkg::K_HEX],
			sb.kind_hits[xce_pkg::K_UTF1], sb.kind_hits[xce_pkg::K_UTF2],
			sb.kind_hits[xce_pkg::K_UTF3]);
		$display("%0d bytes checked incl. a long output stall", sb.bytes_checked);
		if (sb.errors == 0)
			$display("xml_char_escape_utf8 test passed");
		else
			$display("xml_char_escape_utf8 test failed");
		$finish;
	end

endmodule

[files.f]
sv/xce_pkg.sv
sv/xce_front.sv
sv/xce_queue.sv
sv/xce_back.sv
sv/xml_char_escape_utf8.sv
tb/sv/testbench.sv
